// ----- hdl/htbd_pkg.sv -----
// Shared types, codes and constants for the Huffman table bit decoder.
// Has no dependencies. It is used by huffman_table_bit_decoder.
package htbd_pkg;

    // Default sizes of the code table and of the bit accumulator.
    localparam int TABLE_DEPTH_DEF  = 128;
    localparam int MAX_CODE_LEN_DEF = 32;

    // Fixed widths of the transaction fields.
    localparam int OPCODE_W = 2;
    localparam int INDEX_W  = 7;
    localparam int SYMBOL_W = 7;
    localparam int CODE_W   = 32;
    localparam int LENGTH_W = 6;
    localparam int CHAR_W   = 8;
    localparam int STATUS_W = 2;

    // Input opcodes.
    localparam logic [OPCODE_W-1:0] OP_LOAD   = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_DECODE = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd2;

    // ASCII characters that carry a code bit.
    localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'd48;
    localparam logic [CHAR_W-1:0] CHAR_ONE  = 8'd49;

    // Message status, also used as the sticky error code.
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK       = 2'd0,
        STATUS_BAD_CHAR = 2'd1,
        STATUS_BAD_CODE = 2'd2,
        STATUS_TOO_LONG = 2'd3
    } status_t;

    // One table entry as held in the code memory.
    typedef struct packed {
        logic [CODE_W-1:0]   code;
        logic [LENGTH_W-1:0] length;
        logic [SYMBOL_W-1:0] symbol;
    } entry_t;

    // Keep only the code bits below the entry length.
    function automatic logic [CODE_W-1:0] mask_code(input logic [CODE_W-1:0] code,
                                                    input logic [LENGTH_W-1:0] len);
        logic [CODE_W-1:0] res;
        res = '0;
        for (int i = 0; i < CODE_W; i++) begin
            res[i] = code[i] & (i < int'(len));
        end
        return res;
    endfunction

endpackage

// ----- hdl/huffman_table_bit_decoder.sv -----
// Huffman table bit decoder: code table memory, bit accumulator and search sequencer.
// Depends on htbd_pkg for opcodes, status codes and the table entry type.
//
// The block decodes a Huffman bit string one ASCII '0'/'1' character per input
// transaction against a code table of TABLE_DEPTH entries. Load and clear
// transactions produce no result. A decode transaction that appends a bit
// reads the table memory one entry per cycle in index order and stops at the
// first exact code and length match. The table memory has a single read port,
// and the next transaction is not taken until the search is over and any result
// is in the output register. A decode transaction after an error does not search
// the table, and goes through the emit state only when it ends the message.
// A decoded symbol goes out once the output register is free; the transaction that
// ends a message always yields a result with last set and the message status,
// after which the accumulator and the error are cleared and the table is kept.
// A finished result waits in the output register while the next input
// transaction is accepted. The table comes out of reset empty.
module huffman_table_bit_decoder #(
    parameter int TABLE_DEPTH  = htbd_pkg::TABLE_DEPTH_DEF,
    parameter int MAX_CODE_LEN = htbd_pkg::MAX_CODE_LEN_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [htbd_pkg::OPCODE_W-1:0] s_opcode,
    input  logic [htbd_pkg::INDEX_W-1:0]  s_entry_index,
    input  logic [htbd_pkg::SYMBOL_W-1:0] s_entry_symbol,
    input  logic [htbd_pkg::CODE_W-1:0]   s_entry_code,
    input  logic [htbd_pkg::LENGTH_W-1:0] s_entry_length,
    input  logic [htbd_pkg::CHAR_W-1:0]   s_code_char,
    input  logic                          s_end_of_message,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [htbd_pkg::SYMBOL_W-1:0] m_symbol,
    output logic                          m_symbol_valid,
    output logic [htbd_pkg::STATUS_W-1:0] m_status,
    output logic                          m_last
);
    import htbd_pkg::*;

    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int IXW   = $clog2(TABLE_DEPTH + 1);
    localparam int LW    = $clog2(MAX_CODE_LEN + 1);
    localparam int CMP_W = (MAX_CODE_LEN > CODE_W) ? MAX_CODE_LEN : CODE_W;
    localparam int LCW   = (LW > LENGTH_W) ? LW : LENGTH_W;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t                  state_reg, state_next;
    logic [MAX_CODE_LEN-1:0] acc_reg, acc_next;
    logic [LW-1:0]           len_reg, len_next;
    status_t                 error_reg, error_next;
    logic [IXW-1:0]          ix_reg, ix_next;
    logic                    live_reg, live_next;
    logic                    eom_reg, eom_next;
    logic [SYMBOL_W-1:0]     pend_symbol_reg, pend_symbol_next;
    logic                    pend_hit_reg, pend_hit_next;
    status_t                 pend_status_reg, pend_status_next;
    logic                    pend_last_reg, pend_last_next;
    logic                    m_valid_reg, m_valid_next;
    logic [SYMBOL_W-1:0]     m_symbol_reg, m_symbol_next;
    logic                    m_symbol_valid_reg, m_symbol_valid_next;
    status_t                 m_status_reg, m_status_next;
    logic                    m_last_reg, m_last_next;

    // Table storage: entries in a memory, valid bits in flip-flops.
    entry_t                  tbl_mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]  valid_reg;
    entry_t                  rd_entry_reg;
    logic                    rd_valid_reg;

    logic                    accept;
    logic                    load_we;
    logic                    clear_tbl;
    logic [AW-1:0]           waddr;
    logic [AW-1:0]           raddr;
    entry_t                  wentry;
    logic                    hit;
    logic                    last_issued;

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign load_we   = accept && (s_opcode == OP_LOAD) &&
                       (32'(s_entry_index) < 32'(TABLE_DEPTH));
    assign clear_tbl = accept && (s_opcode == OP_CLEAR);
    assign waddr     = AW'(s_entry_index);

    assign wentry.code   = mask_code(s_entry_code, s_entry_length);
    assign wentry.length = s_entry_length;
    assign wentry.symbol = s_entry_symbol;

    // The search reads one entry per cycle; past the end the address parks at zero.
    assign last_issued = (ix_reg == IXW'(TABLE_DEPTH));
    assign raddr       = last_issued ? '0 : AW'(ix_reg);

    // Table memory: one write port for loads, one registered read port for the search.
    always_ff @(posedge aclk) begin
        if (load_we) begin
            tbl_mem[waddr] <= wentry;
        end
        rd_entry_reg <= tbl_mem[raddr];
    end

    // Valid bits clear at once on reset or a clear transaction.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg <= valid_reg[raddr];
            if (clear_tbl) begin
                valid_reg <= '0;
            end else if (load_we) begin
                valid_reg[waddr] <= 1'b1;
            end
        end
    end

    // Compare the entry read last cycle against the accumulator.
    assign hit = live_reg && rd_valid_reg &&
                 (LCW'(rd_entry_reg.length) == LCW'(len_reg)) &&
                 (CMP_W'(rd_entry_reg.code) == CMP_W'(acc_reg));

    // Sequencer and decoder state.
    always_comb begin
        state_next          = state_reg;
        acc_next            = acc_reg;
        len_next            = len_reg;
        error_next          = error_reg;
        ix_next             = ix_reg;
        live_next           = live_reg;
        eom_next            = eom_reg;
        pend_symbol_next    = pend_symbol_reg;
        pend_hit_next       = pend_hit_reg;
        pend_status_next    = pend_status_reg;
        pend_last_next      = pend_last_reg;
        m_valid_next        = m_valid_reg && !m_ready;
        m_symbol_next       = m_symbol_reg;
        m_symbol_valid_next = m_symbol_valid_reg;
        m_status_next       = m_status_reg;
        m_last_next         = m_last_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept && (s_opcode == OP_DECODE)) begin
                    if (error_reg == STATUS_OK && (s_code_char != CHAR_ZERO) &&
                        (s_code_char != CHAR_ONE)) begin
                        error_next = STATUS_BAD_CHAR;
                    end else if (error_reg == STATUS_OK &&
                                 len_reg >= LW'(MAX_CODE_LEN)) begin
                        error_next = STATUS_TOO_LONG;
                    end

                    if (error_next == STATUS_OK) begin
                        // Append the bit and start the table search.
                        acc_next   = {acc_reg[MAX_CODE_LEN-2:0], (s_code_char == CHAR_ONE)};
                        len_next   = len_reg + LW'(1);
                        ix_next    = '0;
                        live_next  = 1'b0;
                        eom_next   = s_end_of_message;
                        state_next = ST_SCAN;
                    end else if (s_end_of_message) begin
                        // A message in error ends with its status alone.
                        pend_symbol_next = '0;
                        pend_hit_next    = 1'b0;
                        pend_status_next = error_next;
                        pend_last_next   = 1'b1;
                        acc_next         = '0;
                        len_next         = '0;
                        error_next       = STATUS_OK;
                        state_next       = ST_EMIT;
                    end
                end
            end
            ST_SCAN: begin
                live_next = !last_issued;
                if (!last_issued) begin
                    ix_next = ix_reg + IXW'(1);
                end
                if (hit) begin
                    // First matching entry wins; the code is complete.
                    pend_symbol_next = rd_entry_reg.symbol;
                    pend_hit_next    = 1'b1;
                    pend_status_next = STATUS_OK;
                    pend_last_next   = eom_reg;
                    acc_next         = '0;
                    len_next         = '0;
                    state_next       = ST_EMIT;
                end else if (live_reg && last_issued) begin
                    // No entry matched. At message end the code is incomplete.
                    if (eom_reg) begin
                        pend_symbol_next = '0;
                        pend_hit_next    = 1'b0;
                        pend_status_next = STATUS_BAD_CODE;
                        pend_last_next   = 1'b1;
                        acc_next         = '0;
                        len_next         = '0;
                        state_next       = ST_EMIT;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next        = 1'b1;
                    m_symbol_next       = pend_symbol_reg;
                    m_symbol_valid_next = pend_hit_reg;
                    m_status_next       = pend_status_reg;
                    m_last_next         = pend_last_reg;
                    state_next          = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            acc_reg     <= '0;
            len_reg     <= '0;
            error_reg   <= STATUS_OK;
            ix_reg      <= '0;
            live_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            acc_reg     <= acc_next;
            len_reg     <= len_next;
            error_reg   <= error_next;
            ix_reg      <= ix_next;
            live_reg    <= live_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        eom_reg            <= eom_next;
        pend_symbol_reg    <= pend_symbol_next;
        pend_hit_reg       <= pend_hit_next;
        pend_status_reg    <= pend_status_next;
        pend_last_reg      <= pend_last_next;
        m_symbol_reg       <= m_symbol_next;
        m_symbol_valid_reg <= m_symbol_valid_next;
        m_status_reg       <= m_status_next;
        m_last_reg         <= m_last_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_symbol       = m_symbol_reg;
    assign m_symbol_valid = m_symbol_valid_reg;
    assign m_status       = m_status_reg;
    assign m_last         = m_last_reg;

    // The accumulator never holds more bits than the longest code.
    assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= LW'(MAX_CODE_LEN))
        else $error("accumulated length exceeds the maximum code length");

    // A result without a symbol exists only to end a message.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_symbol_valid) |-> m_last)
        else $error("symbol-less result that is not last");

    // Results inside a message always report an ok status.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_last) |-> (m_status == STATUS_OK))
        else $error("non-last result carries an error status");

    // After a message ends, the decoder starts the next one clean.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && pend_last_reg) |-> (len_reg == '0 && error_reg == STATUS_OK))
        else $error("decoder state not cleared at end of message");

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for the Huffman table bit decoder: loads code tables, streams
// code characters and checks every decoded symbol and message status against a shadow decoder.
// Depends on htbd_pkg and huffman_table_bit_decoder.
`timescale 1ns / 1ps

module tb_top;
    import htbd_pkg::*;

    localparam int DEPTH        = TABLE_DEPTH_DEF;
    localparam int MAX_LEN      = MAX_CODE_LEN_DEF;
    localparam int DRAIN_CYCLES = 300;
    localparam int DRAIN_LIMIT  = 50000;

    // Opcode that the block must ignore.
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

    // One input transaction, all fields.
    typedef struct packed {
        logic [OPCODE_W-1:0] op;
        logic [INDEX_W-1:0]  idx;
        logic [SYMBOL_W-1:0] sym;
        logic [CODE_W-1:0]   code;
        logic [LENGTH_W-1:0] len;
        logic [CHAR_W-1:0]   ch;
        logic                eom;
    } request_t;

    // One result transaction.
    typedef struct packed {
        logic [SYMBOL_W-1:0] symbol;
        logic                symbol_valid;
        status_t             status;
        logic                last;
    } decoded_t;

    logic                aclk             = 1'b0;
    logic                aresetn          = 1'b0;
    logic                s_valid          = 1'b0;
    logic                s_ready;
    logic [OPCODE_W-1:0] s_opcode         = OP_LOAD;
    logic [INDEX_W-1:0]  s_entry_index    = '0;
    logic [SYMBOL_W-1:0] s_entry_symbol   = '0;
    logic [CODE_W-1:0]   s_entry_code     = '0;
    logic [LENGTH_W-1:0] s_entry_length   = '0;
    logic [CHAR_W-1:0]   s_code_char      = '0;
    logic                s_end_of_message = 1'b0;
    logic                m_valid;
    logic                m_ready          = 1'b0;
    logic [SYMBOL_W-1:0] m_symbol;
    logic                m_symbol_valid;
    logic [STATUS_W-1:0] m_status;
    logic                m_last;

    // Shadow copy of the code table and the decoder state.
    logic [CODE_W-1:0]   tab_code  [DEPTH];
    logic [LENGTH_W-1:0] tab_len   [DEPTH];
    logic [SYMBOL_W-1:0] tab_sym   [DEPTH];
    bit                  tab_valid [DEPTH];
    logic [CODE_W-1:0]   acc_bits  = '0;
    int                  acc_len   = 0;
    status_t             acc_error = STATUS_OK;

    decoded_t decoded_queue[$];

    // Current code set and the message being built from it.
    logic [CODE_W-1:0] leaf_bits[$];
    int                leaf_width[$];
    logic [CHAR_W-1:0] message_chars[$];

    bit tx_quiet        = 1'b0;
    bit rx_quiet        = 1'b0;
    int rx_hold_request = 0;

    int fail_count     = 0;
    int items_sent     = 0;
    int results_seen   = 0;
    int messages_done  = 0;
    int status_seen[4] = '{0, 0, 0, 0};

    huffman_table_bit_decoder DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_opcode         (s_opcode),
        .s_entry_index    (s_entry_index),
        .s_entry_symbol   (s_entry_symbol),
        .s_entry_code     (s_entry_code),
        .s_entry_length   (s_entry_length),
        .s_code_char      (s_code_char),
        .s_end_of_message (s_end_of_message),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_symbol         (m_symbol),
        .m_symbol_valid   (m_symbol_valid),
        .m_status         (m_status),
        .m_last           (m_last)
    );

    always #5 aclk = ~aclk;

    // Idle length for either side: mostly none or short, now and then long.
    function automatic int idle_len(input bit quiet);
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [CHAR_W-1:0] bit_char(input logic b);
        return b ? CHAR_ONE : CHAR_ZERO;
    endfunction

    function automatic logic [CHAR_W-1:0] bad_char();
        logic [CHAR_W-1:0] c;
        do c = CHAR_W'($urandom_range(0, 255)); while (c == CHAR_ZERO || c == CHAR_ONE);
        return c;
    endfunction

    // Request builders; fields that the opcode does not use are random.
    function automatic request_t load_req(input int idx, input logic [SYMBOL_W-1:0] sym,
                                          input logic [CODE_W-1:0] code, input int len);
        request_t r;
        r.op   = OP_LOAD;
        r.idx  = INDEX_W'(idx);
        r.sym  = sym;
        r.code = code;
        r.len  = LENGTH_W'(len);
        r.ch   = CHAR_W'($urandom);
        r.eom  = 1'($urandom);
        return r;
    endfunction

    function automatic request_t decode_req(input logic [CHAR_W-1:0] ch, input logic eom);
        request_t r;
        r.op   = OP_DECODE;
        r.idx  = INDEX_W'($urandom);
        r.sym  = SYMBOL_W'($urandom);
        r.code = $urandom;
        r.len  = LENGTH_W'($urandom);
        r.ch   = ch;
        r.eom  = eom;
        return r;
    endfunction

    function automatic request_t other_req(input logic [OPCODE_W-1:0] op);
        request_t r;
        r      = decode_req(CHAR_W'($urandom), 1'($urandom));
        r.op   = op;
        return r;
    endfunction

    // Keep the code bits below the given length.
    function automatic logic [CODE_W-1:0] keep_low_bits(input logic [CODE_W-1:0] code,
                                                        input int n);
        logic [2*CODE_W-1:0] m;
        m = ({{CODE_W{1'b0}}, {CODE_W{1'b1}}} << n) >> CODE_W;
        return (code & m[CODE_W-1:0]) | ((n >= CODE_W) ? code : '0);
    endfunction

    // Shadow decoder: applies one accepted transaction and queues the result it causes.
    task automatic predict_decoder(input request_t r);
        bit                  hit;
        logic [SYMBOL_W-1:0] hit_sym;
        status_t             st;
        hit     = 1'b0;
        hit_sym = '0;
        case (r.op)
            OP_LOAD: begin
                tab_code[r.idx]  = keep_low_bits(r.code, r.len);
                tab_len[r.idx]   = r.len;
                tab_sym[r.idx]   = r.sym;
                tab_valid[r.idx] = 1'b1;
            end
            OP_CLEAR: begin
                foreach (tab_valid[i]) tab_valid[i] = 1'b0;
            end
            OP_DECODE: begin
                if (acc_error == STATUS_OK) begin
                    if (r.ch != CHAR_ZERO && r.ch != CHAR_ONE) begin
                        acc_error = STATUS_BAD_CHAR;
                    end else if (acc_len >= MAX_LEN) begin
                        acc_error = STATUS_TOO_LONG;
                    end else begin
                        acc_bits = {acc_bits[CODE_W-2:0], r.ch == CHAR_ONE};
                        acc_len++;
                        // First valid entry in index order with equal length and code.
                        for (int i = 0; i < DEPTH; i++) begin
                            if (!hit && tab_valid[i] && tab_len[i] == acc_len
                                    && tab_code[i] == acc_bits) begin
                                hit     = 1'b1;
                                hit_sym = tab_sym[i];
                            end
                        end
                        if (hit) begin
                            acc_bits = '0;
                            acc_len  = 0;
                        end
                    end
                end
                if (!r.eom) begin
                    if (hit) decoded_queue.insert(decoded_queue.size(),
                                                  decoded_t'{hit_sym, 1'b1, STATUS_OK, 1'b0});
                end else begin
                    st = acc_error;
                    if (st == STATUS_OK && acc_len != 0) st = STATUS_BAD_CODE;
                    decoded_queue.insert(decoded_queue.size(),
                                         decoded_t'{hit ? hit_sym : '0, hit, st, 1'b1});
                    acc_bits  = '0;
                    acc_len   = 0;
                    acc_error = STATUS_OK;
                end
            end
            default: ;
        endcase
    endtask

    // Offer one transaction after a random gap and hold it until it is accepted.
    task automatic send_request(input request_t r);
        int gap;
        gap = idle_len(tx_quiet);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_opcode         <= r.op;
        s_entry_index    <= r.idx;
        s_entry_symbol   <= r.sym;
        s_entry_code     <= r.code;
        s_entry_length   <= r.len;
        s_code_char      <= r.ch;
        s_end_of_message <= r.eom;
        s_valid          <= 1'b1;
        do @(posedge aclk); while (s_ready !== 1'b1);
        predict_decoder(r);
        items_sent++;
    endtask

    // Append a code to the message, first bit first.
    task automatic push_code(input logic [CODE_W-1:0] bits, input int width);
        for (int b = width - 1; b >= 0; b--)
            message_chars.insert(message_chars.size(), bit_char(bits[b]));
    endtask

    task automatic send_message(input bit with_nops);
        for (int i = 0; i < message_chars.size(); i++) begin
            if (with_nops && $urandom_range(0, 24) == 0) send_request(other_req(OP_UNUSED));
            send_request(decode_req(message_chars[i], i == message_chars.size() - 1));
        end
    endtask

    // Complete prefix code: split random leaves until the set has the wanted size.
    task automatic build_prefix_code(input int n, input int max_depth);
        int                k;
        logic [CODE_W-1:0] c;
        int                w;
        int                limit;
        // A tree of the given depth holds at most 2**max_depth leaves.
        limit = n;
        if (max_depth < 30 && limit > (1 << max_depth)) limit = 1 << max_depth;
        leaf_bits.delete();
        leaf_width.delete();
        leaf_bits.insert(0, '0);
        leaf_width.insert(0, 0);
        while (leaf_bits.size() < limit) begin
            k = $urandom_range(0, leaf_bits.size() - 1);
            if (leaf_width[k] < max_depth) begin
                c = leaf_bits[k];
                w = leaf_width[k];
                leaf_bits[k]  = c << 1;
                leaf_width[k] = w + 1;
                leaf_bits.insert(leaf_bits.size(), (c << 1) | 1'b1);
                leaf_width.insert(leaf_width.size(), w + 1);
            end
        end
    endtask

    // Load the current code set at distinct random slots, with junk above the code length.
    task automatic load_leaves();
        bit                used [DEPTH];
        int                idx;
        logic [CODE_W-1:0] noise;
        for (int k = 0; k < leaf_bits.size(); k++) begin
            do idx = $urandom_range(0, DEPTH - 1); while (used[idx]);
            used[idx] = 1'b1;
            noise     = $urandom;
            send_request(load_req(idx, SYMBOL_W'($urandom),
                                  leaf_bits[k] | (noise << leaf_width[k]), leaf_width[k]));
        end
    endtask

    // Entries that must never match, or that shadow a real code from another slot.
    task automatic load_junk();
        int k;
        repeat ($urandom_range(1, 3)) begin
            case ($urandom_range(0, 2))
                0: send_request(load_req($urandom_range(0, DEPTH - 1), SYMBOL_W'($urandom),
                                         $urandom, 0));
                1: send_request(load_req($urandom_range(0, DEPTH - 1), SYMBOL_W'($urandom),
                                         $urandom, $urandom_range(MAX_LEN + 1, 63)));
                default: begin
                    k = $urandom_range(0, leaf_bits.size() - 1);
                    send_request(load_req($urandom_range(0, DEPTH - 1), SYMBOL_W'($urandom),
                                          leaf_bits[k], leaf_width[k]));
                end
            endcase
        end
    endtask

    // A handful of hand-picked cases: extremes, priority, the bad character and bad code paths.
    task automatic test_directed_cases();
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
        // Empty table after reset: a lone bit is an incomplete code.
        send_request(decode_req(CHAR_ONE, 1'b1));
        // "0" with junk above its length, "10" twice (lower slot wins), unusable lengths, "110".
        send_request(load_req(0, 7'd65, 32'hFFFF_FFFE, 1));
        send_request(load_req(DEPTH - 1, 7'd127, 32'hAAAA_AAAA, 2));
        send_request(load_req(5, 7'd0, 32'h0000_0002, 2));
        send_request(load_req(6, 7'd1, 32'h0000_0000, 0));
        send_request(load_req(7, 7'd2, 32'h0000_0001, 63));
        send_request(load_req(8, 7'd67, 32'h5555_5556, 3));
        send_request(other_req(OP_UNUSED));
        send_request(decode_req(CHAR_ZERO, 1'b0));
        // Match on the final character carries symbol and status together.
        send_request(decode_req(CHAR_ONE, 1'b0));
        send_request(decode_req(CHAR_ZERO, 1'b1));
        // Symbol mid-message, then an incomplete code at the end.
        send_request(decode_req(CHAR_ONE, 1'b0));
        send_request(decode_req(CHAR_ONE, 1'b0));
        send_request(decode_req(CHAR_ZERO, 1'b0));
        send_request(decode_req(CHAR_ONE, 1'b1));
        // Bad character is sticky: the following valid bit is not decoded.
        send_request(decode_req(8'hFF, 1'b0));
        send_request(decode_req(CHAR_ZERO, 1'b1));
        send_request(decode_req(8'h00, 1'b1));
        // After a table clear nothing matches.
        send_request(other_req(OP_CLEAR));
        send_request(decode_req(CHAR_ZERO, 1'b1));
    endtask

    // Random prefix codes and messages, mostly well formed.
    task automatic test_random_messages(input int target);
        int stop_at;
        int kind;
        int k;
        int w;
        int m;
        stop_at = items_sent + target;
        while (items_sent < stop_at) begin
            tx_quiet = 1'b0;
            rx_quiet = 1'b0;
            build_prefix_code($urandom_range(2, 20), $urandom_range(2, 10));
            if ($urandom_range(0, 4) != 0) send_request(other_req(OP_CLEAR));
            load_leaves();
            if ($urandom_range(0, 3) == 0) load_junk();
            repeat ($urandom_range(3, 8)) begin
                message_chars.delete();
                repeat ($urandom_range(1, 8)) begin
                    k = $urandom_range(0, leaf_bits.size() - 1);
                    push_code(leaf_bits[k], leaf_width[k]);
                end
                kind = $urandom_range(0, 99);
                if (kind < 72) begin
                    // well formed as built
                end else if (kind < 82) begin
                    // Leading part of a code.
                    k = $urandom_range(0, leaf_bits.size() - 1);
                    w = leaf_width[k];
                    if (w > 1) begin
                        m = $urandom_range(1, w - 1);
                        push_code(leaf_bits[k] >> (w - m), m);
                    end else begin
                        push_code($urandom, 1);
                    end
                end else if (kind < 90) begin
                    message_chars.insert($urandom_range(0, message_chars.size()), bad_char());
                end else if (kind < 95) begin
                    message_chars.delete();
                    push_code($urandom, $urandom_range(1, 20));
                end else begin
                    message_chars.delete();
                    repeat ($urandom_range(1, 6)) begin
                        if ($urandom_range(0, 3) == 0)
                            message_chars.insert(message_chars.size(),
                                                 CHAR_W'($urandom_range(0, 255)));
                        else
                            message_chars.insert(message_chars.size(),
                                                 bit_char($urandom_range(0, 1)));
                    end
                end
                tx_quiet = ($urandom_range(0, 4) == 0);
                rx_quiet = ($urandom_range(0, 4) == 0);
                send_message(1'b1);
            end
        end
    endtask

    // Codes of 16 to 32 bits, including all-ones and all-zeros at full length, and overflow.
    task automatic test_long_codes(input int target);
        int                stop_at;
        int                w;
        logic [CODE_W-1:0] c;
        stop_at = items_sent + target;
        while (items_sent < stop_at) begin
            tx_quiet = 1'b0;
            rx_quiet = 1'b0;
            leaf_bits.delete();
            leaf_width.delete();
            repeat ($urandom_range(3, 8)) begin
                w = $urandom_range(16, MAX_LEN);
                c = $urandom;
                case ($urandom_range(0, 5))
                    0: begin w = MAX_LEN; c = '1; end
                    1: begin w = MAX_LEN; c = '0; end
                    default: ;
                endcase
                leaf_bits.insert(leaf_bits.size(), keep_low_bits(c, w));
                leaf_width.insert(leaf_width.size(), w);
            end
            send_request(other_req(OP_CLEAR));
            load_leaves();
            repeat ($urandom_range(2, 5)) begin
                message_chars.delete();
                if ($urandom_range(0, 9) < 7) begin
                    repeat ($urandom_range(1, 2)) begin
                        w = $urandom_range(0, leaf_bits.size() - 1);
                        push_code(leaf_bits[w], leaf_width[w]);
                    end
                end else begin
                    // More bits than the accumulator holds.
                    push_code($urandom, MAX_LEN);
                    push_code($urandom, $urandom_range(1, 6));
                end
                send_message(1'b0);
            end
        end
    endtask

    // One-bit codes give a result per transaction; the receiver holds off so that input stalls.
    task automatic test_output_backpressure();
        send_request(other_req(OP_CLEAR));
        send_request(load_req(0, SYMBOL_W'($urandom), 32'h0, 1));
        send_request(load_req(1, SYMBOL_W'($urandom), 32'h1, 1));
        tx_quiet        = 1'b1;
        rx_quiet        = 1'b0;
        rx_hold_request = 400;
        repeat (60) send_request(decode_req(bit_char($urandom_range(0, 1)),
                                            $urandom_range(0, 7) == 0));
        tx_quiet        = 1'b0;
        rx_hold_request = 150;
        repeat (60) send_request(decode_req(bit_char($urandom_range(0, 1)),
                                            $urandom_range(0, 7) == 0));
        // Close any open message.
        send_request(decode_req(CHAR_ZERO, 1'b1));
    endtask

    // Receiver: random stalls, plus a long hold-off whenever a test asks for one.
    initial begin
        int stall;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (rx_hold_request > 0) begin
                stall           = rx_hold_request;
                rx_hold_request = 0;
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
                m_ready <= 1'b1;
            end else begin
                stall = idle_len(rx_quiet);
                if (stall == 0) begin
                    m_ready <= 1'b1;
                end else begin
                    m_ready <= 1'b0;
                    repeat (stall) @(negedge aclk);
                    m_ready <= 1'b1;
                end
            end
        end
    end

    // Compare each accepted result with the oldest predicted one.
    always @(posedge aclk) begin
        decoded_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (decoded_queue.size() == 0) begin
                $display("%0t: unexpected result: symbol %0d valid %0b status %0d last %0b",
                         $time, m_symbol, m_symbol_valid, m_status, m_last);
                fail_count++;
            end else begin
                want = decoded_queue.pop_front();
                results_seen++;
                if (m_symbol !== want.symbol) begin
                    $display("%0t: symbol mismatch: expected %0d, actual %0d",
                             $time, want.symbol, m_symbol);
                    fail_count++;
                end
                if (m_symbol_valid !== want.symbol_valid) begin
                    $display("%0t: symbol_valid mismatch: expected %0b, actual %0b",
                             $time, want.symbol_valid, m_symbol_valid);
                    fail_count++;
                end
                if (m_status !== want.status) begin
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, want.status, m_status);
                    fail_count++;
                end
                if (m_last !== want.last) begin
                    $display("%0t: last mismatch: expected %0b, actual %0b",
                             $time, want.last, m_last);
                    fail_count++;
                end
                if (want.last) begin
                    messages_done++;
                    status_seen[want.status]++;
                end
            end
        end
    end

    // Let the pipeline drain, report coverage and give the verdict.
    task automatic finish_run();
        int guard;
        @(negedge aclk);
        s_valid <= 1'b0;
        guard = 0;
        while (decoded_queue.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge aclk);
            guard++;
        end
        if (decoded_queue.size() != 0) begin
            $display("%0t: %0d predicted results never arrived", $time, decoded_queue.size());
            fail_count++;
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Sent %0d input transactions; checked %0d results over %0d messages.",
                 items_sent, results_seen, messages_done);
        $display("Message endings: ok %0d, bad character %0d, bad code %0d, too long %0d.",
                 status_seen[STATUS_OK], status_seen[STATUS_BAD_CHAR],
                 status_seen[STATUS_BAD_CODE], status_seen[STATUS_TOO_LONG]);
        if (fail_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    endtask

    initial begin
        foreach (tab_valid[i]) tab_valid[i] = 1'b0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed_cases();
        test_random_messages(1150);
        test_long_codes(330);
        test_output_backpressure();
        finish_run();
    end

    // Watchdog against a hung handshake.
    initial begin
        #30_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule
